### hdl/sqs_pkg.sv
`timescale 1ns / 1ps
// sqs_pkg: shared types and constants of the stack/queue store
// no dependencies; imported by stack_queue_store_core

package sqs_pkg;

  // default number of stored entries
  localparam int unsigned SqsDepth = 64;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_DUMP = 2'd1,
    FN_PEEK = 2'd2,
    FN_POP  = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // configuration register indexes
  typedef enum logic {
    REG_QUEUE_MODE = 1'b0
  } reg_e;

endpackage

### hdl/stack_queue_store_core.sv
`timescale 1ns / 1ps
// stack_queue_store_core: bounded store of signed 32-bit entries, stack or queue
// depends on sqs_pkg
//
// usage:
//   input beats (s_axis) carry an operation in tuser and a push value in tdata.
//   push, peek and pop each give one result beat; dump gives one result beat per
//   stored entry, head first, with tlast on the final one (an empty store gives none).
//   result beats (m_axis) carry status and has_value in tuser, the read entry in tdata.
//   queue_mode is set through the apb port at byte address 0; the user must write
//   it only while idle, as the block itself does not enforce this.
//   push and pop: result registered at the accepting edge, one item per cycle while
//   the result stream is not stalled. peek: the synchronous memory read fills the
//   read data register, which then loads the result register; the next item is
//   taken once the controller is back in idle. dump: each read overlaps the load
//   of the entry before it; the block serves one item at a time.
// reset: head index, entry count, mode and all handshake state clear; the entry
//   memory holds no reset and is only read at places that were written.
// stall: the result register holds its beat while m_axis_tready is low; a dump
//   pauses its memory reads, and no new item is taken until the result can move.

module stack_queue_store_core
  import sqs_pkg::*;
#(
  parameter int unsigned DEPTH = SqsDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] read_value
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_value
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // index and count widths follow the depth
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);
  localparam logic [AW-1:0] IdxLast = AW'(DEPTH - 1);
  localparam logic [SW-1:0] SumWrap = SW'(DEPTH);

  // control state
  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          queue_mode_q;
  logic [CW-1:0] idx_q, idx_d;       // next entry offset to read
  logic [CW-1:0] end_q, end_d;       // number of entries to read
  logic          pend_q, pend_d;     // read data waiting to be loaded
  logic          pend_last_q, pend_last_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  status_e       out_status_d, out_status_q;
  logic          out_hv_d, out_hv_q;
  logic [31:0]   out_val_d, out_val_q;
  logic          out_last_d, out_last_q;

  // entry memory
  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rd_data_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  logic          can_load;
  logic          in_beat;
  func_e         func;

  // ring position of an offset from the head, one compare and subtract
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SumWrap) begin
      sum = sum - SumWrap;
    end
    return sum[AW-1:0];
  endfunction

  assign func     = func_e'(s_axis_tuser);
  assign can_load = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && can_load;
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    end_d        = end_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_load     = 1'b0;
    out_status_d = STAT_OK;
    out_hv_d     = 1'b0;
    out_val_d    = '0;
    out_last_d   = 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = slot(head_q, count_q);
    mem_wdata    = s_axis_tdata;
    mem_re       = 1'b0;
    mem_raddr    = slot(head_q, idx_q);

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          case (func)
            FN_PUSH: begin
              out_load = 1'b1;
              if (count_q == CntFull) begin
                out_status_d = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CntOne;
                if (!queue_mode_q) begin
                  // stack mode: step the head back and write there
                  head_d    = (head_q == '0) ? IdxLast : head_q - AW'(1);
                  mem_waddr = head_d;
                end
              end
            end
            FN_DUMP: begin
              if (count_q != '0) begin
                idx_d   = '0;
                end_d   = count_q;
                state_d = ST_READ;
              end
            end
            FN_PEEK: begin
              if (count_q == '0) begin
                out_load     = 1'b1;
                out_status_d = STAT_EMPTY;
              end else begin
                idx_d   = '0;
                end_d   = CntOne;
                state_d = ST_READ;
              end
            end
            FN_POP: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_status_d = STAT_EMPTY;
              end else begin
                head_d  = slot(head_q, CntOne);
                count_d = count_q - CntOne;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        // move waiting read data into the result register
        if (pend_q && can_load) begin
          out_load   = 1'b1;
          out_hv_d   = 1'b1;
          out_val_d  = rd_data_q;
          out_last_d = pend_last_q;
          pend_d     = 1'b0;
        end
        // issue the next read once its data will have a place to go
        if ((idx_q != end_q) && (!pend_q || can_load)) begin
          mem_re      = 1'b1;
          idx_d       = idx_q + CntOne;
          pend_d      = 1'b1;
          pend_last_d = (idx_d == end_q);
        end
        if ((idx_q == end_q) && (!pend_q || can_load)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_hv_q     <= out_hv_d;
      out_val_q    <= out_val_d;
      out_last_q   <= out_last_d;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_MODE)) begin
      queue_mode_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUEUE_MODE) ? {31'b0, queue_mode_q} : 32'b0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = {out_hv_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule
